// ===== sv/dbsp_pkg.sv =====
// ----------------------------------------------------------------------------
// dbsp_pkg
// Shared types and constants for the DIB byte stream to pixel converter.
// ----------------------------------------------------------------------------
package dbsp_pkg;

	// size limits for the image dimensions
	localparam logic [12:0] MAX_WIDTH = 13'd4096;
	localparam logic [12:0] MAX_ROWS  = 13'd4096;

	// configuration register indexes
	localparam logic [2:0] CFG_DEPTH_MODE     = 3'd0;
	localparam logic [2:0] CFG_IMAGE_WIDTH    = 3'd1;
	localparam logic [2:0] CFG_IMAGE_ROWS     = 3'd2;
	localparam logic [2:0] CFG_ROWS_TOP_DOWN  = 3'd3;
	localparam logic [2:0] CFG_SURFACE_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_SURFACE_HEIGHT = 3'd5;

	// depth selector codes, anything else is 32 bpp
	localparam logic [1:0] DEPTH_16 = 2'd0;
	localparam logic [1:0] DEPTH_24 = 2'd1;
	localparam logic [1:0] DEPTH_32 = 2'd2;

	// queue between front and back, depth a power of two
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0]  depth_mode;
		logic [12:0] image_width;
		logic [12:0] image_rows;
		logic        rows_top_down;
		logic [12:0] surface_width;
		logic [12:0] surface_height;
	} dbsp_cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       start_image;
	} dbsp_in_t;

	typedef struct packed {
		logic        pixel_valid;
		logic [23:0] pixel_rgb;
		logic [11:0] column;
		logic [11:0] surface_row;
		logic        row_end;
		logic        image_end;
	} dbsp_out_t;

	// classified result waiting for conversion
	typedef struct packed {
		logic        pixel_valid;
		logic        is_16bpp;
		logic [23:0] assembly;
		logic [11:0] column;
		logic [11:0] surface_row;
		logic        row_end;
		logic        image_end;
	} dbsp_ent_t;

endpackage

// ===== sv/dbsp_front.sv =====
// ----------------------------------------------------------------------------
// dbsp_front
// Byte counters, pixel assembly, row mapping and clipping; classifies each
// byte and pushes an entry for every byte that gives a result.
// ----------------------------------------------------------------------------
module dbsp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  dbsp_pkg::dbsp_cfg_t cfg,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  dbsp_pkg::dbsp_in_t  byte_data,
	output logic                push_valid,
	input  logic                push_ready,
	output dbsp_pkg::dbsp_ent_t push_data
);
	import dbsp_pkg::*;

	logic [1:0]  byte_phase_q;
	logic [23:0] assembly_q;
	logic [13:0] byte_in_row_q;
	logic [12:0] pixel_column_q;
	logic [12:0] source_row_q;

	logic        accept;
	logic [12:0] w;
	logic [12:0] rows;
	logic [12:0] rows_m1;
	logic [14:0] row_bytes;
	logic [14:0] rounded;
	logic [14:0] stride_m1;
	logic [1:0]  last_phase;
	logic [12:0] copy_px;
	logic [1:0]  phase_e;
	logic [23:0] asm_e;
	logic [13:0] bir_e;
	logic [12:0] col_e;
	logic [12:0] src_e;
	logic [23:0] asm_next;
	logic        in_row;
	logic        complete;
	logic        row_kept;
	logic [12:0] y;
	logic        pix_emit;
	logic        row_last;
	logic        img_last;

	// clamp sizes: zero counts as one, large values saturate
	always_comb begin
		if (cfg.image_width == 13'd0) begin
			w = 13'd1;
		end else if (cfg.image_width > MAX_WIDTH) begin
			w = MAX_WIDTH;
		end else begin
			w = cfg.image_width;
		end
		if (cfg.image_rows == 13'd0) begin
			rows = 13'd1;
		end else if (cfg.image_rows > MAX_ROWS) begin
			rows = MAX_ROWS;
		end else begin
			rows = cfg.image_rows;
		end
	end

	assign rows_m1 = rows - 13'd1;
	assign copy_px = (w < cfg.surface_width) ? w : cfg.surface_width;

	// bytes of pixel data per row and the padded stride
	always_comb begin
		case (cfg.depth_mode)
			DEPTH_16: begin
				row_bytes  = {1'b0, w, 1'b0};
				last_phase = 2'd1;
			end
			DEPTH_24: begin
				row_bytes  = {1'b0, w, 1'b0} + {2'b00, w};
				last_phase = 2'd2;
			end
			default: begin
				row_bytes  = {w, 2'b00};
				last_phase = 2'd3;
			end
		endcase
	end

	assign rounded   = (row_bytes + 15'd3) & 15'h7FFC;
	assign stride_m1 = rounded - 15'd1;

	// counters as seen by this byte, cleared on image start
	assign phase_e = byte_data.start_image ? 2'd0  : byte_phase_q;
	assign asm_e   = byte_data.start_image ? 24'd0 : assembly_q;
	assign bir_e   = byte_data.start_image ? 14'd0 : byte_in_row_q;
	assign col_e   = byte_data.start_image ? 13'd0 : pixel_column_q;
	assign src_e   = byte_data.start_image ? 13'd0 : source_row_q;

	// gather the byte into the pixel word
	always_comb begin
		case (phase_e)
			2'd0:    asm_next = {16'd0, byte_data.data_byte};
			2'd1:    asm_next = asm_e | {8'd0, byte_data.data_byte, 8'd0};
			2'd2:    asm_next = asm_e | {byte_data.data_byte, 16'd0};
			default: asm_next = asm_e;
		endcase
	end

	assign in_row   = {1'b0, bir_e} < row_bytes;
	assign complete = in_row && (phase_e >= last_phase);

	// surface row mapping and row clipping
	always_comb begin
		if (cfg.rows_top_down) begin
			y        = src_e;
			row_kept = src_e < cfg.surface_height;
		end else if (src_e <= rows_m1) begin
			y        = rows_m1 - src_e;
			row_kept = (rows_m1 - src_e) < cfg.surface_height;
		end else begin
			y        = 13'd0;
			row_kept = 1'b0;
		end
	end

	assign pix_emit = complete && row_kept && (col_e < copy_px);
	assign row_last = {1'b0, bir_e} >= stride_m1;
	assign img_last = row_last && (src_e >= rows_m1);

	assign byte_ready = push_ready;
	assign accept     = byte_valid && byte_ready;
	assign push_valid = accept && (pix_emit || img_last);

	// entry for the back end
	always_comb begin
		push_data.pixel_valid = pix_emit;
		push_data.is_16bpp    = cfg.depth_mode == DEPTH_16;
		push_data.assembly    = asm_next;
		push_data.column      = pix_emit ? col_e[11:0] : 12'd0;
		push_data.surface_row = pix_emit ? y[11:0] : 12'd0;
		push_data.row_end     = pix_emit && (col_e == copy_px - 13'd1);
		push_data.image_end   = img_last;
	end

	// counter update on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_phase_q   <= 2'd0;
			assembly_q     <= 24'd0;
			byte_in_row_q  <= 14'd0;
			pixel_column_q <= 13'd0;
			source_row_q   <= 13'd0;
		end else if (accept) begin
			assembly_q <= in_row ? asm_next : asm_e;
			if (row_last) begin
				byte_phase_q   <= 2'd0;
				pixel_column_q <= 13'd0;
				byte_in_row_q  <= 14'd0;
				source_row_q   <= img_last ? 13'd0 : src_e + 13'd1;
			end else begin
				if (!in_row) begin
					byte_phase_q   <= phase_e;
					pixel_column_q <= col_e;
				end else if (complete) begin
					byte_phase_q   <= 2'd0;
					pixel_column_q <= col_e + 13'd1;
				end else begin
					byte_phase_q   <= phase_e + 2'd1;
					pixel_column_q <= col_e;
				end
				byte_in_row_q <= bir_e + 14'd1;
				source_row_q  <= src_e;
			end
		end
	end

endmodule

// ===== sv/dbsp_queue.sv =====
// ----------------------------------------------------------------------------
// dbsp_queue
// Short queue of classified entries between front and back.
// ----------------------------------------------------------------------------
module dbsp_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  dbsp_pkg::dbsp_ent_t push_data,
	output logic                pop_valid,
	input  logic                pop,
	output dbsp_pkg::dbsp_ent_t pop_data
);
	import dbsp_pkg::*;

	localparam logic [QPTR_W:0] FULL = QPTR_W'(QUEUE_DEPTH - 1) + (QPTR_W + 1)'(1);

	dbsp_ent_t         entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = count_q != FULL;
	assign pop_valid  = count_q != '0;
	assign pop_data   = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + (QPTR_W + 1)'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - (QPTR_W + 1)'(1);
			end
		end
	end

	// front never pushes into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push_valid |-> count_q != FULL)
		else $error("push into full queue");

	// back never pops an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	// fill count follows push without pop
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + (QPTR_W + 1)'(1))
		else $error("fill count lost a push");

	// pointers stay the count apart
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q[QPTR_W-1:0] == QPTR_W'(wr_ptr_q - rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule

// ===== sv/dbsp_back.sv =====
// ----------------------------------------------------------------------------
// dbsp_back
// Converts queued entries to RGB888 and holds them in the output register.
// ----------------------------------------------------------------------------
module dbsp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_valid,
	output logic                pop,
	input  dbsp_pkg::dbsp_ent_t pop_data,
	output logic                pix_valid,
	input  logic                pix_ready,
	output dbsp_pkg::dbsp_out_t pix_data
);
	import dbsp_pkg::*;

	logic      out_valid_q;
	dbsp_out_t out_data_q;
	logic      load;
	logic [23:0] rgb16;
	logic [23:0] rgb;

	// 5-bit channel to 8 bits, high bits repeated below
	function automatic logic [7:0] expand5(input logic [4:0] c);
		expand5 = {c, c[4:2]};
	endfunction

	// pixel conversion
	assign rgb16 = {expand5(pop_data.assembly[14:10]), expand5(pop_data.assembly[9:5]),
		expand5(pop_data.assembly[4:0])};

	always_comb begin
		if (!pop_data.pixel_valid) begin
			rgb = 24'd0;
		end else if (pop_data.is_16bpp) begin
			rgb = rgb16;
		end else begin
			rgb = pop_data.assembly;
		end
	end

	// refill the output register when it is empty or being taken
	assign load = pop_valid && (!out_valid_q || pix_ready);
	assign pop  = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (pix_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.pixel_valid <= pop_data.pixel_valid;
			out_data_q.pixel_rgb   <= rgb;
			out_data_q.column      <= pop_data.column;
			out_data_q.surface_row <= pop_data.surface_row;
			out_data_q.row_end     <= pop_data.row_end;
			out_data_q.image_end   <= pop_data.image_end;
		end
	end

	assign pix_valid = out_valid_q;
	assign pix_data  = out_data_q;

endmodule

// ===== sv/dib_byte_stream_to_pixels.sv =====
// ----------------------------------------------------------------------------
// dib_byte_stream_to_pixels
// DIB pixel buffer, one byte per transfer, to RGB888 pixels with coordinates.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_ready/byte_data) takes the buffer bytes in
//   order; start_image on a byte restarts all counters. pix channel
//   (pix_valid/pix_ready/pix_data) gives one transfer per kept pixel and one
//   on the image's last byte (image_end set, pixel_valid 0 if no pixel).
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while no
//   image byte is in flight; indexes beyond the register list are ignored.
// Timing:
//   one byte per cycle sustained while the queue has room. The front classifies
//   a byte in its transfer cycle and writes the queue at the transfer edge;
//   the output register loads from the queue when empty or being taken.
//   A four-entry queue sits between front and output register; byte_ready
//   drops only when that queue is full, so a stalled receiver backs up into
//   the queue and then halts the byte channel. Bytes that give no result
//   never occupy the queue.
// Reset:
//   arst_n clears counters and queue and loads register defaults
//   (32 bpp, 1x1 image, bottom-up, 1x1 surface).
// ----------------------------------------------------------------------------
module dib_byte_stream_to_pixels (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  dbsp_pkg::dbsp_in_t  byte_data,
	output logic                pix_valid,
	input  logic                pix_ready,
	output dbsp_pkg::dbsp_out_t pix_data,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [12:0]         cfg_wdata
);
	import dbsp_pkg::*;

	dbsp_cfg_t cfg_q;
	logic      push_valid;
	logic      push_ready;
	dbsp_ent_t push_data;
	logic      pop_valid;
	logic      pop;
	dbsp_ent_t pop_data;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.depth_mode     <= DEPTH_32;
			cfg_q.image_width    <= 13'd1;
			cfg_q.image_rows     <= 13'd1;
			cfg_q.rows_top_down  <= 1'b0;
			cfg_q.surface_width  <= 13'd1;
			cfg_q.surface_height <= 13'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEPTH_MODE:     cfg_q.depth_mode     <= cfg_wdata[1:0];
				CFG_IMAGE_WIDTH:    cfg_q.image_width    <= cfg_wdata;
				CFG_IMAGE_ROWS:     cfg_q.image_rows     <= cfg_wdata;
				CFG_ROWS_TOP_DOWN:  cfg_q.rows_top_down  <= cfg_wdata[0];
				CFG_SURFACE_WIDTH:  cfg_q.surface_width  <= cfg_wdata;
				CFG_SURFACE_HEIGHT: cfg_q.surface_height <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// byte classification
	dbsp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// decoupling queue
	dbsp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_data   (pop_data)
	);

	// conversion and output register
	dbsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_data  (pop_data),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data)
	);

endmodule

// ===== verif/tb_dib_byte_stream_to_pixels.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dib_byte_stream_to_pixels
// Self-checking bench for the DIB byte stream to pixel converter. A tracker
// class mirrors the byte, row and image counters, predicts every pixel and
// image-end result, and matches the output transfers against them in order.
// Directed images cover each depth, clipping, zero and oversized sizes and
// register changes mid-image; random images with bursty bytes and a
// stalling receiver follow.
// ----------------------------------------------------------------------------
module tb_dib_byte_stream_to_pixels;
	import dbsp_pkg::*;

	// register indexes past the list, the block ignores them
	localparam logic [2:0] CFG_SPARE_6 = 3'd6;
	localparam logic [2:0] CFG_SPARE_7 = 3'd7;
	// depth selector that falls back to 32 bpp
	localparam logic [1:0] DEPTH_SPARE = 2'd3;

	localparam int unsigned BYTE_TARGET    = 1200;
	localparam int unsigned RESULT_TARGET  = 60;
	localparam int unsigned SETTLE_CYCLES  = 8;
	localparam int unsigned HOLD_CYCLES    = 400;
	localparam int unsigned WATCHDOG_LIMIT = 4000;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_mode_t;

	// tracks the raster position and holds the results still owed by the block
	class raster_tracker_t;
		logic [1:0]  depth;
		logic [12:0] img_w;
		logic [12:0] img_rows;
		logic        first_is_top;
		logic [12:0] surf_w;
		logic [12:0] surf_h;

		logic [1:0]  phase;
		logic [23:0] gathered;
		logic [13:0] byte_pos;
		logic [12:0] col_cnt;
		logic [12:0] src_row;

		dbsp_out_t   owed_pixels[$];
		int unsigned errors;
		int unsigned results_seen;
		int unsigned pixels_kept;
		int unsigned image_ends;

		function new();
			depth        = DEPTH_32;
			img_w        = 13'd1;
			img_rows     = 13'd1;
			first_is_top = 1'b0;
			surf_w       = 13'd1;
			surf_h       = 13'd1;
			errors       = 0;
			results_seen = 0;
			pixels_kept  = 0;
			image_ends   = 0;
			clear_counters();
		endfunction

		function void clear_counters();
			phase    = '0;
			gathered = '0;
			byte_pos = '0;
			col_cnt  = '0;
			src_row  = '0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [12:0] val);
			case (idx)
				CFG_DEPTH_MODE:     depth        = val[1:0];
				CFG_IMAGE_WIDTH:    img_w        = val;
				CFG_IMAGE_ROWS:     img_rows     = val;
				CFG_ROWS_TOP_DOWN:  first_is_top = val[0];
				CFG_SURFACE_WIDTH:  surf_w       = val;
				CFG_SURFACE_HEIGHT: surf_h       = val;
				default: ;
			endcase
		endfunction

		// zero counts as one, large values saturate
		function int unsigned fit_size(logic [12:0] v, logic [12:0] lim);
			if (v == 13'd0)
				return 1;
			return (v > lim) ? lim : v;
		endfunction

		function int unsigned px_bytes();
			case (depth)
				DEPTH_16: return 2;
				DEPTH_24: return 3;
				default:  return 4;
			endcase
		endfunction

		function int unsigned row_stride();
			int unsigned w;
			w = fit_size(img_w, MAX_WIDTH);
			return ((w * px_bytes() * 8 + 31) / 32) * 4;
		endfunction

		function int unsigned image_bytes();
			return row_stride() * fit_size(img_rows, MAX_ROWS);
		endfunction

		function logic [7:0] widen5(logic [4:0] c);
			return {c, c[4:2]};
		endfunction

		// advance the raster by one accepted byte, queue any result it causes
		function void take_byte(dbsp_in_t b);
			int unsigned w, rows, bpb, stride, keep_w, y;
			logic        row_kept, row_last, img_last, emit;
			dbsp_out_t   e;
			w      = fit_size(img_w, MAX_WIDTH);
			rows   = fit_size(img_rows, MAX_ROWS);
			bpb    = px_bytes();
			stride = row_stride();
			keep_w = (w < surf_w) ? w : surf_w;
			emit   = 1'b0;
			e      = '0;
			y      = 0;

			if (b.start_image)
				clear_counters();

			// pixel bytes, pad bytes fall through
			if (byte_pos < w * bpb) begin
				if (phase == 2'd0)
					gathered = {16'h0, b.data_byte};
				else if (phase < 2'd3)
					gathered = gathered | ({16'h0, b.data_byte} << (8 * phase));

				if (phase >= bpb - 1) begin
					if (first_is_top) begin
						y = src_row;
						row_kept = (y < surf_h);
					end else if (src_row <= rows - 1) begin
						y = rows - 1 - src_row;
						row_kept = (y < surf_h);
					end else begin
						y = 0;
						row_kept = 1'b0;
					end
					if (row_kept && col_cnt < keep_w) begin
						e.pixel_valid = 1'b1;
						if (bpb == 2)
							e.pixel_rgb = {widen5(gathered[14:10]), widen5(gathered[9:5]),
								widen5(gathered[4:0])};
						else
							e.pixel_rgb = gathered;
						e.column      = col_cnt[11:0];
						e.surface_row = y[11:0];
						e.row_end     = (col_cnt == keep_w - 1);
						emit = 1'b1;
					end
					col_cnt = col_cnt + 1'b1;
					phase   = '0;
				end else begin
					phase = phase + 1'b1;
				end
			end

			// row and image boundaries
			row_last = (byte_pos >= stride - 1);
			img_last = row_last && (src_row >= rows - 1);
			if (row_last) begin
				byte_pos = '0;
				col_cnt  = '0;
				phase    = '0;
				src_row  = img_last ? 13'd0 : src_row + 1'b1;
			end else begin
				byte_pos = byte_pos + 1'b1;
			end
			if (img_last) begin
				e.image_end = 1'b1;
				emit = 1'b1;
			end
			if (emit)
				owed_pixels.push_back(e);
		endfunction

		task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got,
				want);
		endtask

		// compare one output transfer with the oldest owed result
		task match_pixel(dbsp_out_t got);
			dbsp_out_t want;
			results_seen++;
			if (owed_pixels.size() == 0) begin
				report_mismatch("result with none owed", 64'(got), 64'd0);
				return;
			end
			want = owed_pixels.pop_front();
			if (got.pixel_valid !== want.pixel_valid)
				report_mismatch("pixel_valid", 64'(got.pixel_valid), 64'(want.pixel_valid));
			if (got.pixel_rgb !== want.pixel_rgb)
				report_mismatch("pixel_rgb", 64'(got.pixel_rgb), 64'(want.pixel_rgb));
			if (got.column !== want.column)
				report_mismatch("column", 64'(got.column), 64'(want.column));
			if (got.surface_row !== want.surface_row)
				report_mismatch("surface_row", 64'(got.surface_row), 64'(want.surface_row));
			if (got.row_end !== want.row_end)
				report_mismatch("row_end", 64'(got.row_end), 64'(want.row_end));
			if (got.image_end !== want.image_end)
				report_mismatch("image_end", 64'(got.image_end), 64'(want.image_end));
			if (want.pixel_valid)
				pixels_kept++;
			if (want.image_end)
				image_ends++;
		endtask
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	dbsp_in_t    byte_data  = '0;
	logic        pix_valid;
	logic        pix_ready  = 1'b0;
	dbsp_out_t   pix_data;
	logic        cfg_we     = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [12:0] cfg_wdata  = '0;

	raster_tracker_t trk = new();

	logic        steady     = 1'b0;
	logic        hold_req   = 1'b0;
	int unsigned holds_done = 0;
	int unsigned burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned cfg_writes = 0;
	int unsigned quiet_cycles = 0;
	rx_mode_t    rx_mode    = RX_OPEN;
	int unsigned rx_left    = 0;
	int unsigned rx_tick    = 0;

	dib_byte_stream_to_pixels i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_data  (byte_data),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix_data   (pix_data),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// transfer monitor: check results first, then predict from the new byte
	always @(posedge clk) begin
		if (arst_n) begin
			if (pix_valid && pix_ready)
				trk.match_pixel(pix_data);
			if (byte_valid && byte_ready)
				trk.take_byte(byte_data);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (byte_valid && byte_ready) || (pix_valid && pix_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results owed", quiet_cycles,
				trk.owed_pixels.size());
			$display("tb_dib_byte_stream_to_pixels: errors");
			$finish;
		end
	end

	// receiver: stall pattern in windows, long hold-off on request
	always begin
		@(negedge clk);
		if (hold_req) begin
			pix_ready <= 1'b0;
			repeat (HOLD_CYCLES) @(negedge clk);
			hold_req = 1'b0;
			holds_done++;
		end else begin
			if (rx_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_left = $urandom_range(20, 80);
			end
			rx_left--;
			rx_tick++;
			if (steady)
				pix_ready <= 1'b1;
			else begin
				case (rx_mode)
					RX_OPEN:     pix_ready <= 1'b1;
					RX_COIN:     pix_ready <= 1'($urandom_range(0, 1));
					RX_PERIODIC: pix_ready <= ((rx_tick % 4) != 3);
					default:     pix_ready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// offer one byte and wait for its transfer, with bursts and gaps
	task automatic send_byte(input logic [7:0] d, input logic s);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			if (steady)
				gap = 0;
			else if ($urandom_range(0, 3) == 0)
				gap = $urandom_range(10, 40);
			else
				gap = $urandom_range(0, 4);
			if (gap != 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		byte_data  <= '{data_byte: d, start_image: s};
		bytes_sent++;
		do @(posedge clk); while (!byte_ready);
		@(negedge clk);
	endtask

	task automatic send_run(input int unsigned n, input logic first_start);
		int unsigned i;
		for (i = 0; i < n; i++)
			send_byte(8'($urandom), (i == 0) ? first_start : 1'b0);
	endtask

	// stop offering, wait for every owed result, then let the front drain
	task automatic settle();
		byte_valid <= 1'b0;
		while (trk.owed_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [12:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		trk.set_reg(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [1:0] d, input logic [12:0] w, input logic [12:0] r,
			input logic td, input logic [12:0] sw, input logic [12:0] sh);
		settle();
		cfg_write(CFG_DEPTH_MODE, 13'(d));
		cfg_write(CFG_IMAGE_WIDTH, w);
		cfg_write(CFG_IMAGE_ROWS, r);
		cfg_write(CFG_ROWS_TOP_DOWN, 13'(td));
		cfg_write(CFG_SURFACE_WIDTH, sw);
		cfg_write(CFG_SURFACE_HEIGHT, sh);
	endtask

	// small image, mostly in range, sometimes clipped or degenerate
	task automatic random_config();
		int unsigned pick, w, r;
		logic [1:0]  d;
		pick = $urandom_range(0, 9);
		d = (pick < 3) ? DEPTH_16 : (pick < 6) ? DEPTH_24 : (pick < 9) ? DEPTH_32 : DEPTH_SPARE;
		w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 48) : $urandom_range(1, 8);
		r = $urandom_range(1, 4);
		if ($urandom_range(0, 19) == 0)
			w = 0;
		if ($urandom_range(0, 19) == 0)
			r = 0;
		configure(d, 13'(w), 13'(r), 1'($urandom_range(0, 1)), 13'($urandom_range(0, w + 2)),
			13'($urandom_range(0, r + 2)));
	endtask

	// wide image while the receiver holds off, so the queue fills and bytes stall
	task automatic pressure_image();
		configure(DEPTH_24, 13'd40, 13'd3, 1'b0, 13'd40, 13'd3);
		hold_req = 1'b1;
		send_run(trk.image_bytes(), 1'b1);
	endtask

	initial begin
		int unsigned rnd_bytes0, rnd_results0, kind, n, cut;
		logic [2:0]  idx;
		logic [12:0] val;
		logic        second_hold;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset defaults: 32 bpp 1x1, alpha dropped, then a second image by wrap
		send_byte(8'h12, 1'b1);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);

		// 16 bpp: full channels, then top bit only; image end lands on a pad byte
		configure(DEPTH_16, 13'd1, 13'd1, 1'b0, 13'd1, 13'd1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h7F, 1'b0);
		send_byte(8'h11, 1'b0);
		send_byte(8'h22, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);

		// 24 bpp, then the spare depth selector
		settle();
		cfg_write(CFG_DEPTH_MODE, 13'(DEPTH_24));
		send_run(4, 1'b1);
		settle();
		cfg_write(CFG_DEPTH_MODE, 13'(DEPTH_SPARE));
		send_run(4, 1'b1);

		// zero image size counts as one; zero surface keeps nothing
		configure(DEPTH_32, 13'd0, 13'd0, 1'b1, 13'd0, 13'd0);
		send_run(4, 1'b1);
		settle();
		cfg_write(CFG_SURFACE_WIDTH, 13'd1);
		cfg_write(CFG_SPARE_6, 13'h1FFF);
		cfg_write(CFG_SPARE_7, 13'h0AAA);
		send_run(4, 1'b1);

		// row count cut mid-image: bottom-up row beyond the count is dropped
		configure(DEPTH_32, 13'd2, 13'd3, 1'b0, 13'd2, 13'd3);
		send_run(16, 1'b1);
		settle();
		cfg_write(CFG_IMAGE_ROWS, 13'd1);
		send_run(8, 1'b0);

		// depth lowered in the middle of a pixel
		configure(DEPTH_32, 13'd2, 13'd1, 1'b1, 13'd2, 13'd1);
		send_run(3, 1'b1);
		settle();
		cfg_write(CFG_DEPTH_MODE, 13'(DEPTH_16));
		send_run(8, 1'b0);

		// head of the widest row and tallest image, then oversized sizes that
		// saturate; these images are cut short after a few bytes
		configure(DEPTH_16, 13'd4096, 13'd1, 1'b0, 13'd4096, 13'd4096);
		send_run(8, 1'b1);
		configure(DEPTH_16, 13'd1, 13'd4096, 1'b0, 13'd1, 13'd4096);
		send_run(8, 1'b1);
		configure(DEPTH_16, 13'h1FFF, 13'd1, 1'b1, 13'h1FFF, 13'h1FFF);
		send_run(8, 1'b1);
		configure(DEPTH_16, 13'd1, 13'h1FFF, 1'b0, 13'd1, 13'h1FFF);
		send_run(8, 1'b1);

		// random images
		rnd_bytes0   = bytes_sent;
		rnd_results0 = trk.results_seen;
		second_hold  = 1'b0;
		pressure_image();
		while ((bytes_sent - rnd_bytes0) < BYTE_TARGET ||
				(trk.results_seen - rnd_results0) < RESULT_TARGET) begin
			if (!second_hold && (bytes_sent - rnd_bytes0) > BYTE_TARGET / 2) begin
				pressure_image();
				second_hold = 1'b1;
			end
			kind = $urandom_range(0, 9);
			random_config();
			n = trk.image_bytes();
			if (kind <= 5) begin
				// well-formed image, sometimes relying on the wrap instead of start
				send_run(n, ($urandom_range(0, 5) != 0));
			end else if (kind == 6) begin
				// image cut short, noise with stray starts, then a clean image
				send_run($urandom_range(1, n), 1'b1);
				repeat ($urandom_range(1, 12))
					send_byte(8'($urandom), ($urandom_range(0, 7) == 0));
				send_run(n, 1'b1);
			end else if (kind <= 8) begin
				// one register changed mid-image
				cut = $urandom_range(1, n);
				send_run(cut, 1'b1);
				settle();
				idx = 3'($urandom_range(0, 7));
				case (idx)
					CFG_DEPTH_MODE:     val = 13'($urandom_range(0, 3));
					CFG_IMAGE_WIDTH:    val = 13'($urandom_range(0, 12));
					CFG_IMAGE_ROWS:     val = 13'($urandom_range(0, 5));
					CFG_ROWS_TOP_DOWN:  val = 13'($urandom_range(0, 1));
					CFG_SURFACE_WIDTH,
					CFG_SURFACE_HEIGHT: val = 13'($urandom_range(0, 14));
					default:            val = 13'($urandom);
				endcase
				cfg_write(idx, val);
				send_run(trk.image_bytes(), 1'b0);
			end else begin
				// back to back on both sides
				steady = 1'b1;
				send_run(n, 1'b1);
				settle();
				steady = 1'b0;
			end
		end

		settle();
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (trk.owed_pixels.size() != 0)
			trk.report_mismatch("results never arrived", 64'(trk.owed_pixels.size()), 64'd0);

		$display("run: %0d bytes, %0d register writes, %0d receiver hold-offs", bytes_sent,
			cfg_writes, holds_done);
		$display("run: %0d results, %0d kept pixels, %0d image ends, %0d mismatches",
			trk.results_seen, trk.pixels_kept, trk.image_ends, trk.errors);
		if (trk.errors == 0)
			$display("tb_dib_byte_stream_to_pixels: clean");
		else
			$display("tb_dib_byte_stream_to_pixels: errors");
		$finish;
	end

endmodule
